// ===== sv/wtso_pkg.sv =====
// Shared types and fixed constants for the window three-sigma outlier flag block.
// No dependencies; imported by the controller, datapath and top level.
package wtso_pkg;

    localparam int AMT_W      = 25;   // amount_cents width
    localparam int FILL_W     = 5;    // window_fill width
    localparam int IN_DATA_W  = 32;   // amount + confirm, padded to bytes
    localparam int OUT_DATA_W = 8;    // flagged + recorded + window_fill, padded

    // controller -> datapath step commands
    typedef struct packed {
        logic load;     // capture the request
        logic p1;       // n*m, S*S, n*Q
        logic p2;       // d, variance, squares of new and oldest entry
        logic p3;       // d*d, 9*variance
        logic commit;   // decide, update window, load result
    } wtso_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic out_busy; // result register still held by the sink
    } wtso_sts_t;

endpackage

// ===== sv/wtso_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wtso_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 30
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/wtso_ctrl.sv =====
// Sequencing state machine for the outlier flag block.
// Depends on wtso_pkg (command and status structs).
module wtso_ctrl
    import wtso_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  wtso_sts_t sts,
    output wtso_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_P1   = 3'd1;
    localparam logic [2:0] ST_P2   = 3'd2;
    localparam logic [2:0] ST_P3   = 3'd3;
    localparam logic [2:0] ST_DEC  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_P1;
                end
            end
            ST_P1:
            begin
                cmd.p1     = 1'b1;
                state_next = ST_P2;
            end
            ST_P2:
            begin
                cmd.p2     = 1'b1;
                state_next = ST_P3;
            end
            ST_P3:
            begin
                cmd.p3     = 1'b1;
                state_next = ST_DEC;
            end
            ST_DEC:
            begin
                // hold the decision until the result register is free
                if (!sts.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/wtso_dp.sv =====
// Datapath: magnitude, exact three-sigma test, window sums and ring, result register.
// Depends on wtso_pkg and wtso_ram.
module wtso_dp
    import wtso_pkg::*;
#(
    parameter int WINDOW_DEPTH   = 30,
    parameter int MAGNITUDE_BITS = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  wtso_cmd_t         cmd,
    output wtso_sts_t         sts,
    input  logic [AMT_W-1:0]  amount_cents,
    input  logic              confirm,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              flagged,
    output logic              recorded,
    output logic [FILL_W-1:0] window_fill
);

    localparam int MAG_W  = MAGNITUDE_BITS;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int SUM_W  = MAG_W + CNT_W;
    localparam int SQ_W   = 2 * MAG_W + CNT_W;
    localparam int VAR_W  = 2 * SUM_W;
    localparam int V9_W   = VAR_W + 4;
    localparam logic [AMT_W-1:0]  MAG_MAX_EXT = AMT_W'((64'd1 << MAG_W) - 64'd1);
    localparam logic [CNT_W-1:0]  DEPTH_CNT   = CNT_W'(WINDOW_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(WINDOW_DEPTH - 1);

    // window state
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;

    // per-request working registers
    logic [MAG_W-1:0]  m_reg;
    logic              conf_reg;
    logic [SUM_W-1:0]  nm_reg;
    logic [VAR_W-1:0]  ss_reg;
    logic [VAR_W-1:0]  nq_reg;
    logic [SUM_W-1:0]  d_reg;
    logic              pos_reg;
    logic [VAR_W-1:0]  var_reg;
    logic [MAG_W-1:0]  old_reg;
    logic [2*MAG_W-1:0] old_sq_reg;
    logic [2*MAG_W-1:0] m_sq_reg;
    logic [VAR_W-1:0]  dd_reg;
    logic [V9_W-1:0]   var9_reg;

    // result register
    logic              out_valid_reg;
    logic              flag_out_reg;
    logic              rec_out_reg;
    logic [FILL_W-1:0] fill_out_reg;

    logic [AMT_W-1:0]  amt_abs;
    logic [MAG_W-1:0]  mag;
    logic [MAG_W-1:0]  ram_rdata;
    logic              full;
    logic              flag;
    logic              rec;
    logic [VAR_W-1:0]  ss_prod;
    logic [VAR_W-1:0]  nq_prod;
    logic [VAR_W-1:0]  dd_prod;

    // magnitude, saturated to the stored width
    always_comb
    begin
        amt_abs = amount_cents[AMT_W-1] ? (~amount_cents + 1'b1) : amount_cents;
        if (amt_abs > MAG_MAX_EXT)
        begin
            mag = '1;
        end
        else
        begin
            mag = amt_abs[MAG_W-1:0];
        end
    end

    assign ss_prod = sum_reg * sum_reg;
    assign nq_prod = VAR_W'(fill_reg) * VAR_W'(sq_reg);
    assign dd_prod = d_reg * d_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            m_reg    <= mag;
            conf_reg <= confirm;
        end
        if (cmd.p1)
        begin
            nm_reg <= SUM_W'(fill_reg) * SUM_W'(m_reg);
            ss_reg <= ss_prod;
            nq_reg <= nq_prod;
        end
        if (cmd.p2)
        begin
            d_reg      <= nm_reg - sum_reg;
            pos_reg    <= nm_reg > sum_reg;   // false for an empty window
            var_reg    <= nq_reg - ss_reg;
            old_reg    <= ram_rdata;
            old_sq_reg <= ram_rdata * ram_rdata;
            m_sq_reg   <= m_reg * m_reg;
        end
        if (cmd.p3)
        begin
            dd_reg   <= dd_prod;
            var9_reg <= {1'b0, var_reg, 3'b000} + V9_W'(var_reg);
        end
    end

    assign full = (fill_reg == DEPTH_CNT);
    assign flag = pos_reg & ({4'b0000, dd_reg} > var9_reg);
    assign rec  = ~flag | conf_reg;

    always_comb
    begin
        fill_next = fill_reg;
        slot_next = slot_reg;
        sum_next  = sum_reg;
        sq_next   = sq_reg;
        if (cmd.commit && rec)
        begin
            if (full)
            begin
                sum_next = sum_reg - SUM_W'(old_reg) + SUM_W'(m_reg);
                sq_next  = sq_reg - SQ_W'(old_sq_reg) + SQ_W'(m_sq_reg);
            end
            else
            begin
                fill_next = fill_reg + 1'b1;
                sum_next  = sum_reg + SUM_W'(m_reg);
                sq_next   = sq_reg + SQ_W'(m_sq_reg);
            end
            slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            slot_reg      <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            slot_reg <= slot_next;
            sum_reg  <= sum_next;
            sq_reg   <= sq_next;
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            flag_out_reg <= flag;
            rec_out_reg  <= rec;
            fill_out_reg <= FILL_W'(fill_next);
        end
    end

    // oldest entry is read at the write slot; read data settles before p2
    wtso_ram #(
        .WIDTH (MAG_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.commit & rec),
        .waddr (slot_reg),
        .wdata (m_reg),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    assign sts.out_busy = out_valid_reg & ~out_ready;
    assign out_valid    = out_valid_reg;
    assign flagged      = flag_out_reg;
    assign recorded     = rec_out_reg;
    assign window_fill  = fill_out_reg;

endmodule

// ===== sv/window_three_sigma_outlier_flag_top.sv =====
// Sequence: a result is valid once its accepted request has passed three
//   arithmetic steps, then a decision step that loads the result.
// Flow: no new request is taken until the last has run the controller's step
//   sequence through the registered multipliers of the variance test; a result
//   still held by the sink stalls the decision step and so the next request.
// Reset: rst_n is asynchronous, active low; clears window count, sums, write
//   slot, controller state and output valid. Ring contents are not cleared.
module window_three_sigma_outlier_flag_top
    import wtso_pkg::*;
#(
    parameter int WINDOW_DEPTH   = 30,
    parameter int MAGNITUDE_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // request stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [24:0] amount_cents (signed), [25] confirm, [31:26] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] flagged, [1] recorded, [6:2] window_fill, [7] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // The block keeps the last WINDOW_DEPTH recorded magnitudes with their
    // running sum S and sum of squares Q. A request is flagged when, with
    // d = n*|x| - S, d > 0 and d*d > 9*(n*Q - S*S): the exact integer form of
    // "above mean plus three population standard deviations". An empty window
    // gives d = 0 and never flags. The magnitude enters the window unless it
    // was flagged without confirm; a full window drops its oldest entry.

    wtso_cmd_t         cmd;
    wtso_sts_t         sts;
    logic              flagged;
    logic              recorded;
    logic [FILL_W-1:0] window_fill;

    wtso_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wtso_dp #(
        .WINDOW_DEPTH   (WINDOW_DEPTH),
        .MAGNITUDE_BITS (MAGNITUDE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .amount_cents (s_axis_tdata[AMT_W-1:0]),
        .confirm      (s_axis_tdata[AMT_W]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .flagged      (flagged),
        .recorded     (recorded),
        .window_fill  (window_fill)
    );

    // pack result fields, lowest field first
    assign m_axis_tdata = {1'b0, window_fill, recorded, flagged};

endmodule

// ===== bench/window_three_sigma_outlier_flag_top_test.sv =====
// Self-checking bench for window_three_sigma_outlier_flag_top: directed corner
// requests, then random runs of similar amounts with spikes, plus noise bursts.
// Depends on wtso_pkg and the top level; no files, arguments or seeds are read.
module window_three_sigma_outlier_flag_top_test
    import wtso_pkg::*;
();

    localparam int WIN_DEPTH  = 30;
    localparam int MAG_BITS   = 24;
    localparam int MAG_MAX    = (1 << MAG_BITS) - 1;
    localparam int RAND_ITEMS = 700;
    localparam int CYCLE_CAP  = 200000;   // timeout for the whole run
    localparam int MAX_SHOWN  = 10;
    localparam int CALM_FROM  = 300;      // accepted-request window with no idling
    localparam int CALM_TO    = 450;

    // one pending request for the driver
    typedef struct {
        logic [AMT_W-1:0] amount;
        logic             confirm;
        bit               hold;      // wait for every result before presenting it
    } txn_t;

    // one predicted result
    typedef struct {
        logic              flagged;
        logic              recorded;
        logic [FILL_W-1:0] fill;
    } verdict_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    txn_t     txn_q[$];
    verdict_t verdict_q[$];

    // predicted window state
    bit [MAG_BITS-1:0] win_mag[WIN_DEPTH];
    int                win_slot = 0;
    int                win_count = 0;
    bit [28:0]         win_sum = '0;
    bit [52:0]         win_sqsum = '0;

    int mismatch_cnt = 0;
    int sent_cnt = 0;
    int cycle_cnt = 0;

    window_three_sigma_outlier_flag_top #(
        .WINDOW_DEPTH  (WIN_DEPTH),
        .MAGNITUDE_BITS(MAG_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Scores one accepted amount against the window and updates the window.
    // Exact test on wide integers: flag when d > 0 and d*d > 9*(n*Q - S*S).
    task automatic screen_amount(input logic [AMT_W-1:0] amount, input logic confirm,
                                 output verdict_t v);
        bit [AMT_W-1:0]    mag_raw;
        bit [MAG_BITS-1:0] mag;
        bit [127:0]        n_w, m_w, s_w, q_w, n_m, dev, spread_w, old_w;
        mag_raw = amount[AMT_W-1] ? (~amount + 1'b1) : amount;
        // the most negative amount has a magnitude one past the stored range
        mag = (mag_raw > MAG_MAX) ? MAG_MAX[MAG_BITS-1:0] : mag_raw[MAG_BITS-1:0];
        n_w = win_count;
        m_w = mag;
        s_w = win_sum;
        q_w = win_sqsum;
        n_m = n_w * m_w;
        v.flagged = 1'b0;
        if (win_count != 0 && n_m > s_w)
        begin
            dev      = n_m - s_w;
            spread_w = n_w * q_w - s_w * s_w;
            v.flagged = (dev * dev) > (spread_w * 128'd9);
        end
        v.recorded = !v.flagged || confirm;
        if (v.recorded)
        begin
            if (win_count >= WIN_DEPTH)
            begin
                old_w     = win_mag[win_slot];
                win_sum   = win_sum - old_w[28:0];
                win_sqsum = win_sqsum - 53'(old_w * old_w);
            end
            else
            begin
                win_count++;
            end
            win_mag[win_slot] = mag;
            win_sum   = win_sum + mag;
            win_sqsum = win_sqsum + 53'(m_w * m_w);
            win_slot  = (win_slot + 1) % WIN_DEPTH;
        end
        v.fill = win_count[FILL_W-1:0];
    endtask

    function automatic bit take_break();
        if (sent_cnt >= CALM_FROM && sent_cnt < CALM_TO)
            return 1'b0;
        return $urandom_range(0, 99) < 25;
    endfunction

    function automatic int clamp_mag(input int m);
        if (m < 0)
            return 0;
        if (m > MAG_MAX)
            return MAG_MAX;
        return m;
    endfunction

    task automatic add_txn(input int signed amount, input logic confirm, input bit hold);
        txn_t t;
        t.amount  = amount[AMT_W-1:0];
        t.confirm = confirm;
        t.hold    = hold;
        txn_q.insert(txn_q.size(), t);
    endtask

    // Driver: presents queued requests, holds tvalid until accepted, and runs the
    // predictor on each accepted request.
    always @(posedge clk)
    begin
        verdict_t v;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                screen_amount(txn_q[0].amount, txn_q[0].confirm, v);
                verdict_q.insert(verdict_q.size(), v);
                void'(txn_q.pop_front());
                sent_cnt <= sent_cnt + 1;
            end
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (txn_q.size() != 0 && !take_break() &&
                    !(txn_q[0].hold && verdict_q.size() != 0))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(IN_DATA_W-AMT_W-1){1'b0}}, txn_q[0].confirm,
                                      txn_q[0].amount};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_SHOWN)
                        $display("unexpected result: flagged=%0d recorded=%0d fill=%0d",
                                 m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[6:2]);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (m_axis_tdata[0] !== want.flagged ||
                        m_axis_tdata[1] !== want.recorded ||
                        m_axis_tdata[6:2] !== want.fill)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_SHOWN)
                            $display({"mismatch: expected flagged=%0d recorded=%0d ",
                                      "fill=%0d, got flagged=%0d recorded=%0d fill=%0d"},
                                     want.flagged, want.recorded, want.fill,
                                     m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[6:2]);
                    end
                end
            end
            m_axis_tready <= !take_break();
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int made, base, spread, len, mag, kind;
        bit first;

        // directed: empty window, confirm with no flag, confirmed and dropped
        // outliers, the exact three-sigma boundary, saturation of the most
        // negative amount, and the field extremes
        add_txn(0, 1'b1, 1'b0);             // empty window never flags
        add_txn(2, 1'b1, 1'b0);             // zero variance, flagged, kept
        add_txn(-5, 1'b0, 1'b0);            // mean 1, sigma 1: above 4, dropped
        add_txn(-4, 1'b0, 1'b0);            // exactly mean + 3 sigma: not flagged
        add_txn(16777215, 1'b1, 1'b0);      // largest positive, flagged and kept
        add_txn(-16777216, 1'b0, 1'b0);     // saturates to the largest magnitude
        add_txn(-16777215, 1'b0, 1'b0);
        add_txn(0, 1'b0, 1'b0);
        add_txn(1, 1'b1, 1'b0);             // confirm while not flagged
        add_txn(-1, 1'b0, 1'b0);
        for (int i = 0; i < 8; i++)
            add_txn(7, 1'b0, 1'b0);
        add_txn(16777215, 1'b0, 1'b0);
        add_txn(-16777216, 1'b1, 1'b0);

        // random: mostly runs of similar magnitudes, often closed by a spike near or past
        // the three-sigma line, with bursts of full-range noise in between
        made  = 0;
        first = 1'b1;
        while (made < RAND_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 8)
            begin
                case ($urandom_range(0, 3))
                    0: base = $urandom_range(0, 200);
                    1: base = $urandom_range(0, 100000);
                    2: base = $urandom_range(0, MAG_MAX);
                    default: base = MAG_MAX - $urandom_range(0, 1000);
                endcase
                if ($urandom_range(0, 3) == 0)
                    spread = 0;
                else
                    spread = (base >> $urandom_range(1, 8)) + $urandom_range(0, 3);
                len = $urandom_range(5, 40);
                for (int i = 0; i < len; i++)
                begin
                    mag = clamp_mag(base + $urandom_range(0, 2 * spread) - spread);
                    add_txn($urandom_range(0, 1) ? -mag : mag, 1'($urandom_range(0, 1)),
                            first || made == RAND_ITEMS / 2);
                    first = 1'b0;
                    made++;
                end
                if ($urandom_range(0, 9) < 6)
                begin
                    mag = clamp_mag(base + spread * $urandom_range(2, 6) +
                                    $urandom_range(0, spread) + $urandom_range(0, 3));
                    if (mag == MAG_MAX && $urandom_range(0, 1))
                        add_txn(-16777216, 1'($urandom_range(0, 1)), 1'b0);
                    else
                        add_txn($urandom_range(0, 1) ? -mag : mag,
                                1'($urandom_range(0, 1)), 1'b0);
                    made++;
                end
            end
            else
            begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                begin
                    add_txn(int'($urandom()), 1'($urandom_range(0, 1)), 1'b0);
                    made++;
                end
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (txn_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/wtso_pkg.sv
sv/wtso_ram.sv
sv/wtso_ctrl.sv
sv/wtso_dp.sv
sv/window_three_sigma_outlier_flag_top.sv
bench/window_three_sigma_outlier_flag_top_test.sv
